FILE: rtl/p2r_pkg.sv
// Shared constants for the polar to rectangular converter.
// Holds the CORDIC gain, the guard width and the arctangent table in 32-bit turns.
// No dependencies.
package p2r_pkg;

    // Turn word width: 2^32 equals one full turn
    localparam int TURN_BITS = 32;

    // Fraction bits kept below the amplitude LSB in the datapath
    localparam int GUARD = 16;

    // Largest number of CORDIC iterations the table supports
    localparam int MAX_STEPS = 30;

    // CORDIC gain 0.6072529350 in Q1.31
    localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

    typedef logic [TURN_BITS-1:0] t_turn;

    // atan(2^-i) in 32-bit turn units
    localparam t_turn ATAN_TURN32 [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

endpackage

FILE: rtl/p2r_cordic_stage.sv
// One registered CORDIC rotation step (rotation mode) of the converter pipeline.
// Depends on p2r_pkg for the arctangent table and the turn type.
module p2r_cordic_stage #(
    parameter int W     = 34,
    parameter int SHIFT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    input  p2r_pkg::t_turn        i_z,
    output logic                  o_valid,
    output logic signed [W-1:0]   o_x,
    output logic signed [W-1:0]   o_y,
    output p2r_pkg::t_turn        o_z
);
    import p2r_pkg::*;

    logic                r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    t_turn               r_z;

    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    t_turn               n_z;
    logic signed [W-1:0] w_xs;
    logic signed [W-1:0] w_ys;

    // Rotate toward zero residual angle; sign of z picks the direction
    always_comb begin
        w_xs = i_x >>> SHIFT;
        w_ys = i_y >>> SHIFT;
        if (!i_z[TURN_BITS-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN_TURN32[SHIFT];
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN_TURN32[SHIFT];
        end
    end

    // Advance valid bit on enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance payload on enable
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

FILE: rtl/polar_to_rectangular.sv
// Top level of the polar to rectangular converter: gain pre-scale, quadrant fold,
// CORDIC stage chain and output rounding. Depends on p2r_pkg and p2r_cordic_stage.
//
// Converts a signed Q1.(AMP_BITS-1) amplitude and a binary-angle phase (2^ANGLE_BITS
// is one turn) into amplitude*cos and amplitude*sin in the amplitude's format, with
// round half up and saturation. The pipeline takes one item every cycle while the
// output is not stalled, and STEPS = min(AMP_BITS+4, 30) is the number of CORDIC
// stages. The registers in order are one multiply stage, one fold stage, STEPS
// rotation stages and one rounding stage. The whole pipeline holds while a finished
// result waits on the output.
module polar_to_rectangular #(
    parameter int AMP_BITS   = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [AMP_BITS-1:0]  i_amplitude,
    input  logic [ANGLE_BITS-1:0]       i_phase_angle,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [AMP_BITS-1:0]  o_real_part,
    output logic signed [AMP_BITS-1:0]  o_imag_part
);
    import p2r_pkg::*;

    localparam int STEPS  = (AMP_BITS + 4 > MAX_STEPS) ? MAX_STEPS : (AMP_BITS + 4);
    localparam int W      = AMP_BITS + GUARD + 2;
    localparam int PROD_W = AMP_BITS + 32;
    localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(1) << (GUARD - 2);
    localparam logic signed [W:0] OUT_RND = (W+1)'(1) << (GUARD - 1);
    localparam logic signed [W:0] OUT_HI  = ((W+1)'(1) << (AMP_BITS - 1)) - (W+1)'(1);
    localparam logic signed [W:0] OUT_LO  = -OUT_HI - (W+1)'(1);

    // Round half up, drop guard bits and saturate to the amplitude range
    function automatic logic signed [AMP_BITS-1:0] round_sat(input logic signed [W-1:0] v);
        logic signed [W:0] s;
        logic signed [W:0] q;
        s = {v[W-1], v} + OUT_RND;
        q = s >>> GUARD;
        if (q > OUT_HI) begin
            return OUT_HI[AMP_BITS-1:0];
        end else if (q < OUT_LO) begin
            return OUT_LO[AMP_BITS-1:0];
        end else begin
            return q[AMP_BITS-1:0];
        end
    endfunction

    logic w_advance;

    // Multiply stage
    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_m_prod;
    logic                     r_m_fold;
    t_turn                    r_m_z;
    logic signed [PROD_W-1:0] n_m_prod;
    t_turn                    w_z_in;
    logic                     n_m_fold;

    // Fold stage
    logic                     r_f_valid;
    logic signed [W-1:0]      r_f_x;
    t_turn                    r_f_z;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [W-1:0]      n_f_x;

    // Output stage
    logic                      r_out_valid;
    logic signed [AMP_BITS-1:0] r_real;
    logic signed [AMP_BITS-1:0] r_imag;

    // Rotation chain taps
    logic                w_c_valid [STEPS+1];
    logic signed [W-1:0] w_c_x     [STEPS+1];
    logic signed [W-1:0] w_c_y     [STEPS+1];
    t_turn               w_c_z     [STEPS+1];

    // Hold the whole pipeline while a result waits
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = w_advance;

    // Scale by the CORDIC gain; map phase onto a 32-bit turn and fold the
    // left half plane onto the right one
    always_comb begin
        n_m_prod = i_amplitude * GAIN_Q31;
        w_z_in   = TURN_BITS'(i_phase_angle) << (TURN_BITS - ANGLE_BITS);
        n_m_fold = w_z_in[TURN_BITS-1] ^ w_z_in[TURN_BITS-2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_advance) begin
            r_m_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_m_prod <= n_m_prod;
            r_m_fold <= n_m_fold;
            r_m_z    <= {w_z_in[TURN_BITS-1] ^ n_m_fold, w_z_in[TURN_BITS-2:0]};
        end
    end

    // Round the scaled amplitude to the guard format, negate on a fold
    always_comb begin
        w_rnd = (r_m_prod + PROD_RND) >>> (GUARD - 1);
        n_f_x = r_m_fold ? -w_rnd[W-1:0] : w_rnd[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_advance) begin
            r_f_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_f_x <= n_f_x;
            r_f_z <= r_m_z;
        end
    end

    // Rotation stages, one iteration each
    assign w_c_valid[0] = r_f_valid;
    assign w_c_x[0]     = r_f_x;
    assign w_c_y[0]     = '0;
    assign w_c_z[0]     = r_f_z;

    for (genvar g = 0; g < STEPS; g++) begin : g_rot
        p2r_cordic_stage #(
            .W     (W),
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_advance),
            .i_valid (w_c_valid[g]),
            .i_x     (w_c_x[g]),
            .i_y     (w_c_y[g]),
            .i_z     (w_c_z[g]),
            .o_valid (w_c_valid[g+1]),
            .o_x     (w_c_x[g+1]),
            .o_y     (w_c_y[g+1]),
            .o_z     (w_c_z[g+1])
        );
    end

    // Round, saturate and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_c_valid[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_real <= round_sat(w_c_x[STEPS]);
            r_imag <= round_sat(w_c_y[STEPS]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_real_part = r_real;
    assign o_imag_part = r_imag;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_m_valid && !r_f_valid && !o_out_valid)
        else $error("pipeline not empty after reset");

    // Folded residual angle lies within one quarter turn either side of zero
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> r_m_z[TURN_BITS-1] == r_m_z[TURN_BITS-2])
        else $error("quadrant fold left angle outside right half plane");

    // An item in the multiply stage moves to the fold stage on advance
    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_m_valid |=> r_f_valid)
        else $error("item lost between multiply and fold stages");

    // A stall freezes the inner stages
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_f_valid) && $stable(r_f_x) && $stable(r_m_valid))
        else $error("inner stage changed during stall");

endmodule
